// ----- design/assert_macros.svh -----
// Assertion macros used by jpd_checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset
`define JPD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every rising edge, reset included
`define JPD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- design/jpd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package jpd_pkg;
  localparam int JOINTS = 6;
  localparam int ANG_W = 20;
  localparam int DELTA_W = ANG_W + 1;
  localparam int SPACING_W = 19;
  // wide enough for step counts up to 64
  localparam int N_W = 7;
  localparam int REACH_W = SPACING_W + N_W;
  localparam int DIST_W = 2 * ANG_W + 3;

  localparam logic [2:0] ADDR_STEP_LIMIT = 3'd0;
  localparam logic [SPACING_W-1:0] SPACING_RESET = SPACING_W'(655);

  // one classified waypoint handed from front to back
  typedef struct packed {
    logic [JOINTS-1:0][ANG_W-1:0] base;
    logic [JOINTS-1:0]            neg;
    logic [JOINTS-1:0][ANG_W-1:0] qd;
    logic [JOINTS-1:0][N_W-1:0]   rd;
    logic [N_W-1:0]               n;
    logic                         capped;
  } entry_t;
endpackage
`default_nettype wire

// ----- design/joint_path_densifier.sv -----
// Joint-space path densifier.
// Input channel: in_valid/in_stall with joint_0..joint_5 and first_of_path;
// a transaction is taken when in_valid is high and in_stall low.
// Output channel: out_valid/out_stall with out_joint_0..5, last_of_run and
// step_capped; one transaction per interpolated point.
// Config: APB-style, step_limit at byte address 0; write it only when idle.
// A pass-through waypoint (first_of_path or spacing zero) holds the input
// until its entry is pushed into the queue. A continued waypoint holds the
// input while the front squares and sums the differences, tries each
// candidate n in the step-count search (a multiply, then a compare), runs
// the per-joint restoring dividers and hands over to the queue. Its n points
// then follow one per cycle while out_stall is low, with the output idle
// between runs.
// A two-entry queue lets the front classify the next waypoint while the back
// still emits points.
// Reset clears all control, restores step_limit to 655 and empties the
// queue; the stored waypoint is undefined until the first one arrives.
// With out_valid and out_stall high, the output holds and the back pauses.
`timescale 1ns / 1ps
`default_nettype none
module joint_path_densifier #(
  parameter int MAX_SEGMENTS = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic signed [19:0]  joint_0,
  input  logic signed [19:0]  joint_1,
  input  logic signed [19:0]  joint_2,
  input  logic signed [19:0]  joint_3,
  input  logic signed [19:0]  joint_4,
  input  logic signed [19:0]  joint_5,
  input  logic                first_of_path,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [19:0]  out_joint_0,
  output logic signed [19:0]  out_joint_1,
  output logic signed [19:0]  out_joint_2,
  output logic signed [19:0]  out_joint_3,
  output logic signed [19:0]  out_joint_4,
  output logic signed [19:0]  out_joint_5,
  output logic                last_of_run,
  output logic                step_capped
);
  import jpd_pkg::*;

  logic [SPACING_W-1:0] step_limit;
  logic [JOINTS-1:0][ANG_W-1:0] joint;
  logic [JOINTS-1:0][ANG_W-1:0] out_joint;
  logic push, q_full, pop, q_not_empty;
  entry_t push_entry, head;

  // register access
  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_STEP_LIMIT) ? 32'(step_limit) : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_limit <= SPACING_RESET;
    end else if (psel && penable && pwrite && paddr == ADDR_STEP_LIMIT) begin
      step_limit <= pwdata[SPACING_W-1:0];
    end
  end

  assign joint[0] = joint_0;
  assign joint[1] = joint_1;
  assign joint[2] = joint_2;
  assign joint[3] = joint_3;
  assign joint[4] = joint_4;
  assign joint[5] = joint_5;
  assign out_joint_0 = out_joint[0];
  assign out_joint_1 = out_joint[1];
  assign out_joint_2 = out_joint[2];
  assign out_joint_3 = out_joint[3];
  assign out_joint_4 = out_joint[4];
  assign out_joint_5 = out_joint[5];

  jpd_front #(.MAX_SEGMENTS(MAX_SEGMENTS)) u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .joint(joint), .first_of_path(first_of_path), .step_limit(step_limit),
    .push(push), .push_entry(push_entry), .q_full(q_full)
  );

  jpd_queue u_queue (
    .clk(clk), .rst(rst), .push(push), .push_entry(push_entry), .full(q_full),
    .pop(pop), .not_empty(q_not_empty), .head(head)
  );

  jpd_back u_back (
    .clk(clk), .rst(rst), .q_not_empty(q_not_empty), .head(head), .pop(pop),
    .out_valid(out_valid), .out_stall(out_stall), .out_joint(out_joint),
    .last_of_run(last_of_run), .step_capped(step_capped)
  );
endmodule
`default_nettype wire

// ----- design/jpd_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
module jpd_front #(
  parameter int MAX_SEGMENTS = 64
) (
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic                                         in_valid,
  output logic                                         in_stall,
  input  logic [jpd_pkg::JOINTS-1:0][jpd_pkg::ANG_W-1:0] joint,
  input  logic                                         first_of_path,
  input  logic [jpd_pkg::SPACING_W-1:0]                step_limit,
  output logic                                         push,
  output jpd_pkg::entry_t                              push_entry,
  input  logic                                         q_full
);
  import jpd_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SQ   = 3'd1;
  localparam logic [2:0] S_SUM  = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_CMP  = 3'd4;
  localparam logic [2:0] S_DIV  = 3'd5;
  localparam logic [2:0] S_PUSH = 3'd6;

  logic [2:0] state;
  logic [JOINTS-1:0][ANG_W-1:0] prev;
  logic [JOINTS-1:0][ANG_W-1:0] mag;
  logic [JOINTS-1:0][2*ANG_W-1:0] sq;
  logic [JOINTS-1:0][N_W-1:0] rem;
  logic [DIST_W-1:0] dist2;
  logic [REACH_W-1:0] reach;
  logic [2*REACH_W-1:0] rsq;
  logic [N_W-1:0] k;
  logic [4:0] cnt;
  entry_t e;

  logic [JOINTS-1:0][DELTA_W-1:0] delta;
  logic [DIST_W-1:0] sum;
  logic [JOINTS-1:0][N_W:0] remsh;
  logic [JOINTS-1:0] qbit;
  logic accept;

  assign in_stall = (state != S_IDLE);
  assign accept = in_valid && !in_stall;
  assign push = (state == S_PUSH) && !q_full;
  assign push_entry = e;

  // differences, distance sum and one divider step per lane
  always_comb begin
    sum = '0;
    for (int j = 0; j < JOINTS; j++) begin
      delta[j] = {joint[j][ANG_W-1], joint[j]} - {prev[j][ANG_W-1], prev[j]};
      sum = sum + DIST_W'(sq[j]);
      remsh[j] = {rem[j], mag[j][ANG_W-1]};
      qbit[j] = (remsh[j] >= {1'b0, e.n});
    end
  end

  // sequence the classification of one waypoint
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            for (int j = 0; j < JOINTS; j++) begin
              prev[j] <= joint[j];
              mag[j] <= delta[j][DELTA_W-1] ? ANG_W'(-delta[j]) : ANG_W'(delta[j]);
              rem[j] <= '0;
            end
            e.capped <= 1'b0;
            cnt <= '0;
            if (first_of_path || step_limit == '0) begin
              // pass through: zero step from the waypoint itself
              for (int j = 0; j < JOINTS; j++) begin
                e.base[j] <= joint[j];
                e.neg[j] <= 1'b0;
                e.qd[j] <= '0;
                e.rd[j] <= '0;
              end
              e.n <= N_W'(1);
              state <= S_PUSH;
            end else begin
              for (int j = 0; j < JOINTS; j++) begin
                e.base[j] <= prev[j];
                e.neg[j] <= delta[j][DELTA_W-1];
              end
              state <= S_SQ;
            end
          end
        end
        S_SQ: begin
          for (int j = 0; j < JOINTS; j++) sq[j] <= mag[j] * mag[j];
          state <= S_SUM;
        end
        S_SUM: begin
          dist2 <= sum;
          k <= N_W'(1);
          reach <= REACH_W'(step_limit);
          state <= S_MUL;
        end
        S_MUL: begin
          rsq <= reach * reach;
          state <= S_CMP;
        end
        S_CMP: begin
          // stop at the first n covering the distance, or the cap
          if (rsq >= (2*REACH_W)'(dist2)) begin
            e.n <= k;
            state <= S_DIV;
          end else if (k == N_W'(MAX_SEGMENTS)) begin
            e.n <= k;
            e.capped <= 1'b1;
            state <= S_DIV;
          end else begin
            k <= k + N_W'(1);
            reach <= reach + REACH_W'(step_limit);
            state <= S_MUL;
          end
        end
        S_DIV: begin
          // restoring division of each magnitude by the step count
          for (int j = 0; j < JOINTS; j++) begin
            rem[j] <= qbit[j] ? N_W'(remsh[j] - {1'b0, e.n}) : remsh[j][N_W-1:0];
            mag[j] <= {mag[j][ANG_W-2:0], qbit[j]};
            e.qd[j] <= {e.qd[j][ANG_W-2:0], qbit[j]};
            if (cnt == 5'(ANG_W - 1)) e.rd[j] <= qbit[j] ? N_W'(remsh[j] - {1'b0, e.n})
                                                       : remsh[j][N_W-1:0];
          end
          cnt <= cnt + 5'd1;
          if (cnt == 5'(ANG_W - 1)) state <= S_PUSH;
        end
        S_PUSH: begin
          if (!q_full) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ----- design/jpd_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
module jpd_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  jpd_pkg::entry_t push_entry,
  output logic            full,
  input  logic            pop,
  output logic            not_empty,
  output jpd_pkg::entry_t head
);
  import jpd_pkg::*;

  entry_t slot [2];
  logic wr_ptr, rd_ptr;
  logic [1:0] count;

  assign full = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign head = slot[rd_ptr];

  // hold two waypoints between front and back
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot[wr_ptr] <= push_entry;
  end
endmodule
`default_nettype wire

// ----- design/jpd_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
module jpd_back (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          q_not_empty,
  input  jpd_pkg::entry_t                               head,
  output logic                                          pop,
  output logic                                          out_valid,
  input  logic                                          out_stall,
  output logic [jpd_pkg::JOINTS-1:0][jpd_pkg::ANG_W-1:0] out_joint,
  output logic                                          last_of_run,
  output logic                                          step_capped
);
  import jpd_pkg::*;

  logic active;
  entry_t e;
  logic [N_W-1:0] k;
  logic [JOINTS-1:0][ANG_W-1:0] q;
  logic [JOINTS-1:0][N_W:0] r;

  logic advance;
  logic [JOINTS-1:0][N_W+1:0] rsum;
  logic [JOINTS-1:0][N_W:0] rn;
  logic [JOINTS-1:0][ANG_W-1:0] qn;
  logic [JOINTS-1:0][DELTA_W-1:0] pt;

  assign advance = active && (!out_valid || !out_stall);
  assign pop = !active && q_not_empty;

  // next rounded step per joint: running quotient and remainder
  always_comb begin
    for (int j = 0; j < JOINTS; j++) begin
      rsum[j] = {1'b0, r[j]} + {1'b0, e.rd[j], 1'b0};
      if (rsum[j] >= {1'b0, e.n, 1'b0}) begin
        rn[j] = (N_W+1)'(rsum[j] - {1'b0, e.n, 1'b0});
        qn[j] = q[j] + e.qd[j] + ANG_W'(1);
      end else begin
        rn[j] = rsum[j][N_W:0];
        qn[j] = q[j] + e.qd[j];
      end
      pt[j] = e.neg[j] ? {e.base[j][ANG_W-1], e.base[j]} - {1'b0, qn[j]}
                       : {e.base[j][ANG_W-1], e.base[j]} + {1'b0, qn[j]};
    end
  end

  // walk the steps of one run
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (pop) begin
      active <= 1'b1;
    end else if (advance && k == e.n) begin
      active <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      e <= head;
      k <= N_W'(1);
      for (int j = 0; j < JOINTS; j++) begin
        q[j] <= '0;
        r[j] <= {1'b0, head.n};
      end
    end else if (advance) begin
      k <= k + N_W'(1);
      q <= qn;
      r <= rn;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int j = 0; j < JOINTS; j++) out_joint[j] <= pt[j][ANG_W-1:0];
      last_of_run <= (k == e.n);
      step_capped <= e.capped;
    end
  end
endmodule
`default_nettype wire

// ----- design/jpd_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module jpd_checker (
  input logic clk,
  input logic rst,
  input logic pready,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic last_of_run
);
  // nothing leaves the block in the cycle after reset
  `JPD_ASSERT_ALWAYS(a_reset_quiet, rst |=> !out_valid, "output valid after reset")
  // one waypoint at a time: the front closes after a transaction
  `JPD_ASSERT(a_front_busy, (in_valid && !in_stall) |=> in_stall, "front took two waypoints")
  // a stalled point stays valid and keeps last_of_run
  `JPD_ASSERT(a_hold, (out_valid && out_stall) |=> (out_valid && $stable(last_of_run)),
    "stalled point changed")
  `JPD_ASSERT(a_ready, pready, "config port not ready")
endmodule

bind joint_path_densifier jpd_checker u_checker (
  .clk(clk), .rst(rst), .pready(pready), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .last_of_run(last_of_run)
);
`default_nettype wire

// ----- tb/sv/joint_path_densifier_checker.sv -----
`timescale 1ns / 1ps
module joint_path_densifier_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [18:0]        cfg_spacing,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic signed [19:0] joint_0,
  input  logic signed [19:0] joint_1,
  input  logic signed [19:0] joint_2,
  input  logic signed [19:0] joint_3,
  input  logic signed [19:0] joint_4,
  input  logic signed [19:0] joint_5,
  input  logic               first_of_path,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [19:0] out_joint_0,
  input  logic signed [19:0] out_joint_1,
  input  logic signed [19:0] out_joint_2,
  input  logic signed [19:0] out_joint_3,
  input  logic signed [19:0] out_joint_4,
  input  logic signed [19:0] out_joint_5,
  input  logic               last_of_run,
  input  logic               step_capped,
  output int                 fail_count,
  output int                 pending,
  output int                 points_seen,
  output int                 capped_seen
);
  import jpd_pkg::*;

  typedef struct packed {
    logic [JOINTS-1:0][ANG_W-1:0] ang;
    logic                         last;
    logic                         capped;
  } point_t;

  localparam int SEG_MAX = 64;

  point_t             point_q[$];
  logic signed [63:0] held_wp[JOINTS];
  logic [18:0]        spacing;

  // Nearest rounding, ties away from zero
  function automatic longint round_div(longint num, longint den);
    longint mag;
    longint q;
    mag = (num < 0) ? -num : num;
    q = (2 * mag + den) / (2 * den);
    return (num < 0) ? -q : q;
  endfunction

  // Expand one waypoint into its interpolated points
  task automatic densify(input logic signed [19:0] wp[JOINTS], input logic start);
    longint dlt[JOINTS];
    longint dist2;
    longint reach;
    int     nseg;
    logic   cap;
    point_t p;
    dist2 = 0;
    for (int j = 0; j < JOINTS; j++) begin
      dlt[j] = longint'(wp[j]) - held_wp[j];
      dist2 += dlt[j] * dlt[j];
    end
    if (start || spacing == 0) begin
      for (int j = 0; j < JOINTS; j++) p.ang[j] = wp[j];
      p.last = 1'b1;
      p.capped = 1'b0;
      point_q = {point_q, p};
    end else begin
      nseg = SEG_MAX;
      cap = 1'b1;
      for (int k = 1; k <= SEG_MAX; k++) begin
        reach = longint'(k) * longint'(spacing);
        if (reach * reach >= dist2) begin
          nseg = k;
          cap = 1'b0;
          break;
        end
      end
      for (int k = 1; k <= nseg; k++) begin
        for (int j = 0; j < JOINTS; j++)
          p.ang[j] = ANG_W'(held_wp[j] + round_div(dlt[j] * k, nseg));
        p.last = (k == nseg);
        p.capped = cap;
        point_q = {point_q, p};
      end
    end
    for (int j = 0; j < JOINTS; j++) held_wp[j] = wp[j];
  endtask

  // Track config, predict on input transactions, compare on output ones
  always @(posedge clk) begin
    logic signed [19:0] wp[JOINTS];
    point_t got;
    point_t exp_p;
    if (rst) begin
      spacing <= SPACING_RESET;
      fail_count <= 0;
      pending <= 0;
      points_seen <= 0;
      capped_seen <= 0;
      for (int j = 0; j < JOINTS; j++) held_wp[j] = 0;
      point_q.delete();
    end else begin
      if (cfg_we) spacing <= cfg_spacing;
      if (out_valid && !out_stall) begin
        got.ang[0] = out_joint_0;
        got.ang[1] = out_joint_1;
        got.ang[2] = out_joint_2;
        got.ang[3] = out_joint_3;
        got.ang[4] = out_joint_4;
        got.ang[5] = out_joint_5;
        got.last = last_of_run;
        got.capped = step_capped;
        points_seen <= points_seen + 1;
        if (step_capped) capped_seen <= capped_seen + 1;
        if (point_q.size() == 0) begin
          $display("%0t: unexpected point, expected none, actual %h", $time, got);
          fail_count <= fail_count + 1;
        end else begin
          exp_p = point_q.pop_front();
          if (got !== exp_p) begin
            $display("%0t: point mismatch, expected %h, actual %h", $time, exp_p, got);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_valid && !in_stall) begin
        wp[0] = joint_0;
        wp[1] = joint_1;
        wp[2] = joint_2;
        wp[3] = joint_3;
        wp[4] = joint_4;
        wp[5] = joint_5;
        densify(wp, first_of_path);
      end
      pending <= point_q.size();
    end
  end
endmodule

// ----- tb/sv/joint_path_densifier_tb.sv -----
`timescale 1ns / 1ps
module joint_path_densifier_tb;
  import jpd_pkg::*;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [2:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [19:0] joint_0 = '0;
  logic signed [19:0] joint_1 = '0;
  logic signed [19:0] joint_2 = '0;
  logic signed [19:0] joint_3 = '0;
  logic signed [19:0] joint_4 = '0;
  logic signed [19:0] joint_5 = '0;
  logic               first_of_path = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [19:0] out_joint_0;
  logic signed [19:0] out_joint_1;
  logic signed [19:0] out_joint_2;
  logic signed [19:0] out_joint_3;
  logic signed [19:0] out_joint_4;
  logic signed [19:0] out_joint_5;
  logic               last_of_run;
  logic               step_capped;
  int                 fail_count;
  int                 pending;
  int                 points_seen;
  int                 capped_seen;
  int                 send_idle_pct = 0;
  int                 recv_stall_pct = 0;
  int                 hold_off = 0;
  int                 waypoints_sent = 0;
  logic signed [19:0] last_wp[6];

  always #5 clk = ~clk;

  joint_path_densifier u_top (.*);

  joint_path_densifier_checker u_chk (
    .clk, .rst,
    .cfg_we(psel && penable && pwrite && pready && paddr == ADDR_STEP_LIMIT),
    .cfg_spacing(pwdata[18:0]),
    .in_valid, .in_stall,
    .joint_0, .joint_1, .joint_2, .joint_3, .joint_4, .joint_5, .first_of_path,
    .out_valid, .out_stall,
    .out_joint_0, .out_joint_1, .out_joint_2, .out_joint_3, .out_joint_4,
    .out_joint_5, .last_of_run, .step_capped,
    .fail_count, .pending, .points_seen, .capped_seen
  );

  // Receiver stall: random, or a long counted hold-off when requested
  always @(posedge clk) begin
    if (hold_off > 0) begin
      out_stall <= 1'b1;
      hold_off <= hold_off - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic write_spacing(input logic [18:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_STEP_LIMIT;
    pwdata <= {13'd0, val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Offer one waypoint after a random gap and hold it until taken
  task automatic send_wp(input logic signed [19:0] a[6], input logic start);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    joint_0 <= a[0];
    joint_1 <= a[1];
    joint_2 <= a[2];
    joint_3 <= a[3];
    joint_4 <= a[4];
    joint_5 <= a[5];
    first_of_path <= start;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    for (int j = 0; j < 6; j++) last_wp[j] = a[j];
    waypoints_sent++;
  endtask

  task automatic drop_valid();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    drop_valid();
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  // Random waypoint: near the last one, or anywhere
  task automatic random_wp(output logic signed [19:0] a[6]);
    int reach;
    reach = $urandom_range(3) == 0 ? 524287 : $urandom_range(4000);
    for (int j = 0; j < 6; j++) begin
      if (reach == 524287) a[j] = 20'($urandom);
      else a[j] = 20'(last_wp[j] + $signed(20'($urandom_range(2 * reach))) - reach);
    end
  endtask

  initial begin
    logic signed [19:0] a[6];
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: path start, same point, extremes, far jump, spacing 0, 1, max
    for (int j = 0; j < 6; j++) a[j] = 20'sh80000;
    send_wp(a, 1'b1);
    send_wp(a, 1'b0);
    for (int j = 0; j < 6; j++) a[j] = 20'sh7FFFF;
    send_wp(a, 1'b0);
    for (int j = 0; j < 6; j++) a[j] = (j % 2) ? 20'sh80000 : 20'sh7FFFF;
    send_wp(a, 1'b0);
    for (int j = 0; j < 6; j++) a[j] = a[j] + ((j % 2) ? 20'sd700 : -20'sd1300);
    send_wp(a, 1'b0);
    for (int j = 0; j < 6; j++) a[j] = 20'sh00000;
    send_wp(a, 1'b1);
    for (int j = 0; j < 6; j++) a[j] = -20'sd1;
    send_wp(a, 1'b0);
    drain();
    write_spacing(19'd0);
    for (int j = 0; j < 6; j++) a[j] = 20'sh55555;
    send_wp(a, 1'b0);
    for (int j = 0; j < 6; j++) a[j] = 20'shAAAAA;
    send_wp(a, 1'b0);
    drain();
    write_spacing(19'h7FFFF);
    for (int j = 0; j < 6; j++) a[j] = 20'sh55555;
    send_wp(a, 1'b0);
    drain();
    write_spacing(19'd1);
    for (int j = 0; j < 6; j++) a[j] = a[j] + 20'sd3;
    send_wp(a, 1'b0);
    drain();

    // Random phases over several spacings and idling patterns
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  write_spacing(19'd655); end
        1: begin send_idle_pct = 68; recv_stall_pct = 0;  write_spacing(19'd200); end
        2: begin send_idle_pct = 0;  recv_stall_pct = 68; write_spacing(19'd1500); end
        3: begin send_idle_pct = 18; recv_stall_pct = 18; write_spacing(19'($urandom)); end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; write_spacing(19'd300); end
      endcase
      if (ph == 4) hold_off = 400;
      for (int i = 0; i < 40; i++) begin
        random_wp(a);
        send_wp(a, $urandom_range(9) == 0);
      end
      drain();
    end

    $display("Sent %0d waypoints, checked %0d points (%0d step-capped).",
             waypoints_sent, points_seen, capped_seen);
    $display("Spacings covered zero, one, max and mid values under mixed idling.");
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Mismatches found");
    $finish;
  end
endmodule
